### hw/rtl/ieh_pkg.sv
// Shared types and constants for the indexed event min-heap.
`default_nettype none

package ieh_pkg;

    localparam int HANDLE_W = 10;
    localparam int SLOT_W   = 10;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 11;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_DOWN = 2'd1;
    localparam logic [1:0] REQ_UP   = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        logic [SLOT_W-1:0]   slot;
    } req_word_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] top_handle;
        logic [KEY_W-1:0]    top_key;
        logic [SLOT_W-1:0]   final_slot;
    } rsp_word_t;

endpackage

`default_nettype wire

### hw/rtl/indexed_event_min_heap_core.sv
// Top level of the indexed event min-heap: request sequencer over three heap memories.
//
// A request word is taken at a rising edge where start is high and busy is low.
// A load request writes a handle and key into a given slot. A sift-down request
// stores the handle's new key and moves the entry down, the smaller child winning
// and the left one on a tie; a sift-up request stores the key and moves the entry
// up, but never above slots 1 and 2. Each request yields one response word on rsp,
// marked by done for exactly one cycle: the root handle, its key and the final slot
// of the entry acted on. The receiver cannot stall, so nothing waits on it.
// One request is handled at a time. A request of type none stores no key and
// only reports the entry's slot. Each heap memory has a single registered read
// port, so a sift reads child or parent handles and keys one after another. The
// default depth is 1024 slots. Reset clears the slot count and the sequencer;
// memory contents are undefined until written. The user must write entry_count
// through the APB port only while idle; the block itself does not enforce it.
// HEAP_DEPTH must be a power of two.
`default_nettype none

module indexed_event_min_heap_core
    import ieh_pkg::*;
#(
    parameter int HEAP_DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire req_word_t         req,
    output logic                   done,
    output rsp_word_t              rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int IDX_W = $clog2(HEAP_DEPTH);
    localparam int LW    = (IDX_W + 2 > COUNT_W + 1) ? IDX_W + 2 : COUNT_W + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOAD    = 4'd1;
    localparam logic [3:0] S_KEYW    = 4'd2;
    localparam logic [3:0] S_POS     = 4'd3;
    localparam logic [3:0] S_DN_C1   = 4'd4;
    localparam logic [3:0] S_DN_C1K  = 4'd5;
    localparam logic [3:0] S_DN_C2K  = 4'd6;
    localparam logic [3:0] S_DN_CMP2 = 4'd7;
    localparam logic [3:0] S_UP_P    = 4'd8;
    localparam logic [3:0] S_UP_PK   = 4'd9;
    localparam logic [3:0] S_UP_CMP  = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;
    localparam logic [3:0] S_TOP0    = 4'd12;
    localparam logic [3:0] S_TOP1    = 4'd13;
    localparam logic [3:0] S_TOP2    = 4'd14;

    logic [3:0]         state_reg, state_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;

    logic [1:0]       req_type_reg, req_type_next;
    logic [IDX_W-1:0] h_reg, h_next;
    logic [KEY_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] h_a_reg, h_a_next;
    logic [IDX_W-1:0] h_b_reg, h_b_next;
    logic             best_c1_reg, best_c1_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [IDX_W-1:0] fin_reg, fin_next;
    logic [IDX_W-1:0] top_h_reg, top_h_next;
    rsp_word_t        rsp_reg, rsp_next;

    logic             sh_we, hs_we, hk_we;
    logic [IDX_W-1:0] sh_wa, hs_wa, hk_wa;
    logic [IDX_W-1:0] sh_wd, hs_wd;
    logic [KEY_W-1:0] hk_wd;
    logic [IDX_W-1:0] sh_ra, hs_ra, hk_ra;
    logic [IDX_W-1:0] sh_rd, hs_rd;
    logic [KEY_W-1:0] hk_rd;

    logic [LW-1:0]    used;
    logic [LW-1:0]    child1;
    logic [LW-1:0]    child2;
    logic [IDX_W-1:0] parent;

    logic             dn_dec;
    logic             dn_mv;
    logic [IDX_W-1:0] dn_slot;
    logic [IDX_W-1:0] dn_h;

    logic cfg_write;

    ieh_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_DEPTH)) u_slot_handles (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_wa),
        .wdata (sh_wd),
        .raddr (sh_ra),
        .rdata (sh_rd)
    );

    ieh_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_DEPTH)) u_handle_slots (
        .clk   (clk),
        .we    (hs_we),
        .waddr (hs_wa),
        .wdata (hs_wd),
        .raddr (hs_ra),
        .rdata (hs_rd)
    );

    ieh_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_handle_keys (
        .clk   (clk),
        .we    (hk_we),
        .waddr (hk_wa),
        .wdata (hk_wd),
        .raddr (hk_ra),
        .rdata (hk_rd)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign pready = 1'b1;

    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ENTRY_COUNT) ? DATA_W'(entry_count_reg) : '0;

    assign used   = (LW'(entry_count_reg) > LW'(HEAP_DEPTH)) ? LW'(HEAP_DEPTH)
                                                             : LW'(entry_count_reg);
    assign child1 = (LW'(pos_reg) << 1) + LW'(1);
    assign child2 = (LW'(pos_reg) << 1) + LW'(2);
    assign parent = (pos_reg - IDX_W'(1)) >> 1;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (cfg_write && (paddr[2] == REG_ENTRY_COUNT))
        begin
            entry_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        req_type_next = req_type_reg;
        h_next        = h_reg;
        k_next        = k_reg;
        s_next        = s_reg;
        pos_next      = pos_reg;
        h_a_next      = h_a_reg;
        h_b_next      = h_b_reg;
        best_c1_next  = best_c1_reg;
        best_key_next = best_key_reg;
        fin_next      = fin_reg;
        top_h_next    = top_h_reg;
        rsp_next      = rsp_reg;
        sh_we = 1'b0;
        sh_wa = '0;
        sh_wd = '0;
        hs_we = 1'b0;
        hs_wa = '0;
        hs_wd = '0;
        hk_we = 1'b0;
        hk_wa = '0;
        hk_wd = '0;
        sh_ra = '0;
        hs_ra = '0;
        hk_ra = '0;
        dn_dec  = 1'b0;
        dn_mv   = 1'b0;
        dn_slot = '0;
        dn_h    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_type_next = req.req_type;
                    h_next        = IDX_W'(req.handle);
                    k_next        = req.key;
                    s_next        = IDX_W'(req.slot);
                    state_next    = (req.req_type == REQ_LOAD) ? S_LOAD : S_KEYW;
                end
            end
            S_LOAD:
            begin
                sh_we = 1'b1;
                sh_wa = s_reg;
                sh_wd = h_reg;
                hs_we = 1'b1;
                hs_wa = h_reg;
                hs_wd = s_reg;
                hk_we = 1'b1;
                hk_wa = h_reg;
                hk_wd = k_reg;
                fin_next   = s_reg;
                state_next = S_TOP0;
            end
            S_KEYW:
            begin
                if (req_type_reg != REQ_NONE)
                begin
                    hk_we = 1'b1;
                    hk_wa = h_reg;
                    hk_wd = k_reg;
                end
                hs_ra      = h_reg;
                state_next = S_POS;
            end
            S_POS:
            begin
                pos_next = hs_rd;
                priority if (req_type_reg == REQ_DOWN)
                begin
                    state_next = S_DN_C1;
                end
                else if (req_type_reg == REQ_UP)
                begin
                    state_next = S_UP_P;
                end
                else
                begin
                    fin_next   = hs_rd;
                    state_next = S_TOP0;
                end
            end
            S_DN_C1:
            begin
                if (child1 < used)
                begin
                    sh_ra      = IDX_W'(child1);
                    state_next = S_DN_C1K;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_C1K:
            begin
                h_a_next = sh_rd;
                hk_ra    = sh_rd;
                if (child2 < used)
                begin
                    sh_ra = IDX_W'(child2);
                end
                state_next = S_DN_C2K;
            end
            S_DN_C2K:
            begin
                best_c1_next  = (hk_rd < k_reg);
                best_key_next = (hk_rd < k_reg) ? hk_rd : k_reg;
                h_b_next      = sh_rd;
                if (child2 < used)
                begin
                    hk_ra      = sh_rd;
                    state_next = S_DN_CMP2;
                end
                else
                begin
                    dn_dec  = 1'b1;
                    dn_mv   = (hk_rd < k_reg);
                    dn_slot = IDX_W'(child1);
                    dn_h    = h_a_reg;
                end
            end
            S_DN_CMP2:
            begin
                dn_dec = 1'b1;
                if (hk_rd < best_key_reg)
                begin
                    dn_mv   = 1'b1;
                    dn_slot = IDX_W'(child2);
                    dn_h    = h_b_reg;
                end
                else
                begin
                    dn_mv   = best_c1_reg;
                    dn_slot = IDX_W'(child1);
                    dn_h    = h_a_reg;
                end
            end
            S_UP_P:
            begin
                if (pos_reg > IDX_W'(2))
                begin
                    sh_ra      = parent;
                    state_next = S_UP_PK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_UP_PK:
            begin
                h_a_next   = sh_rd;
                hk_ra      = sh_rd;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (k_reg >= hk_rd)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    sh_we = 1'b1;
                    sh_wa = pos_reg;
                    sh_wd = h_a_reg;
                    hs_we = 1'b1;
                    hs_wa = h_a_reg;
                    hs_wd = pos_reg;
                    pos_next   = parent;
                    state_next = S_UP_P;
                end
            end
            S_FIN:
            begin
                sh_we = 1'b1;
                sh_wa = pos_reg;
                sh_wd = h_reg;
                hs_we = 1'b1;
                hs_wa = h_reg;
                hs_wd = pos_reg;
                fin_next   = pos_reg;
                state_next = S_TOP0;
            end
            S_TOP0:
            begin
                sh_ra      = '0;
                state_next = S_TOP1;
            end
            S_TOP1:
            begin
                top_h_next = sh_rd;
                hk_ra      = sh_rd;
                state_next = S_TOP2;
            end
            S_TOP2:
            begin
                rsp_next.top_handle = HANDLE_W'(top_h_reg);
                rsp_next.top_key    = hk_rd;
                rsp_next.final_slot = SLOT_W'(fin_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (dn_dec)
        begin
            if (dn_mv)
            begin
                sh_we = 1'b1;
                sh_wa = pos_reg;
                sh_wd = dn_h;
                hs_we = 1'b1;
                hs_wa = dn_h;
                hs_wd = pos_reg;
                pos_next   = dn_slot;
                state_next = S_DN_C1;
            end
            else
            begin
                state_next = S_FIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            entry_count_reg <= entry_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        h_reg        <= h_next;
        k_reg        <= k_next;
        s_reg        <= s_next;
        pos_reg      <= pos_next;
        h_a_reg      <= h_a_next;
        h_b_reg      <= h_b_next;
        best_c1_reg  <= best_c1_next;
        best_key_reg <= best_key_next;
        fin_reg      <= fin_next;
        top_h_reg    <= top_h_next;
        rsp_reg      <= rsp_next;
    end

`ifndef SYNTHESIS
    a_done_after_top: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_TOP2))
        else $error("Response word without a root read.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("Response word while the sequencer is still busy.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not start the sequencer.");

    a_rise_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_CMP) |-> (pos_reg > IDX_W'(2)))
        else $error("Sift-up compared an entry at level one or the root.");

    a_down_move: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DN_C1) && ($past(state_reg) == S_DN_CMP2))
        |-> (pos_reg > $past(pos_reg)))
        else $error("Sift-down did not move to a child slot.");
`endif

endmodule

`default_nettype wire

### hw/rtl/ieh_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module ieh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
